[hw/rtl/mwr_pkg.sv]
// Package for the Manchester word receiver: widths, register indexes,
// reset thresholds, the interval class codes and the shared structs.
// No dependencies; every other file of the block imports it.
package mwr_pkg;

  // Field widths
  localparam int unsigned IV_W      = 16;  // interval and register width
  localparam int unsigned OUT_W     = 16;  // word, position and count width
  localparam int unsigned CFG_IDX_W = 3;

  // Default data word length
  localparam int unsigned WORD_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HALF_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS     = 3'd4;

  // Threshold resets, 144 MHz timer
  localparam logic [IV_W-1:0] HALF_BIT_MAX_RST  = 16'd41;
  localparam logic [IV_W-1:0] BIT_MAX_RST       = 16'd68;
  localparam logic [IV_W-1:0] SYNC_HALF_MAX_RST = 16'd95;
  localparam logic [IV_W-1:0] SYNC_MAX_RST      = 16'd122;
  localparam logic [IV_W-1:0] MAX_WORDS_RST     = 16'd64;

  // Word count saturation value
  localparam logic [OUT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Interval classes decided at the front
  typedef enum logic [2:0] {
    CLS_START = 3'd0,  // start of frame, clears word count
    CLS_HALF  = 3'd1,  // one half-bit
    CLS_FULL  = 3'd2,  // two half-bits
    CLS_SYNC1 = 3'd3,  // sync, one half-bit left pending
    CLS_SYNC2 = 3'd4,  // sync, two half-bits left pending
    CLS_LOST  = 3'd5   // too long, sync lost
  } cls_e;

  typedef struct packed {
    logic [IV_W-1:0] half_bit_max;
    logic [IV_W-1:0] bit_max;
    logic [IV_W-1:0] sync_half_max;
    logic [IV_W-1:0] sync_max;
    logic [IV_W-1:0] max_words;
  } cfg_t;

  // Front to queue handshake
  typedef struct packed {
    logic push;
    cls_e cls;
  } q_wr_t;

  // Queue to back handshake
  typedef struct packed {
    logic valid;
    cls_e cls;
  } q_rd_t;

endpackage

[hw/rtl/mwr_if.sv]
// Valid/ready channel interfaces of the Manchester word receiver:
// edge items in, decoded words out. Depends on mwr_pkg.
interface mwr_in_if import mwr_pkg::*;;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [IV_W-1:0] interval;

  modport source (output valid, operation, interval, input ready);
  modport sink   (input valid, operation, interval, output ready);
endinterface

interface mwr_out_if import mwr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] word;
  logic             is_command;
  logic [OUT_W-1:0] position;
  logic             kept;
  logic             polarity_fixed;

  modport source (output valid, word, is_command, position, kept, polarity_fixed,
                  input ready);
  modport sink   (input valid, word, is_command, position, kept, polarity_fixed,
                  output ready);
endinterface

[hw/rtl/mwr_front.sv]
// Front end: takes edge items and sorts each interval into a class
// against the thresholds. Depends on mwr_pkg and mwr_in_if.
module mwr_front import mwr_pkg::*; (
  mwr_in_if.sink   in_ch,
  input  cfg_t     cfg_i,
  input  logic     q_full_i,
  output q_wr_t    q_wr_o
);

  cls_e cls;

  // Interval classification
  always_comb begin
    if (in_ch.operation) begin
      cls = CLS_START;
    end else if (in_ch.interval <= cfg_i.bit_max) begin
      cls = (in_ch.interval <= cfg_i.half_bit_max) ? CLS_HALF : CLS_FULL;
    end else if (in_ch.interval > cfg_i.sync_max) begin
      cls = CLS_LOST;
    end else begin
      cls = (in_ch.interval <= cfg_i.sync_half_max) ? CLS_SYNC1 : CLS_SYNC2;
    end
  end

  assign in_ch.ready  = ~q_full_i;
  assign q_wr_o.push  = in_ch.valid & ~q_full_i;
  assign q_wr_o.cls   = cls;

endmodule

[hw/rtl/mwr_fifo.sv]
// Two-entry queue of interval classes between front and back.
// Depends on mwr_pkg.
module mwr_fifo import mwr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t q_rd_o
);

  cls_e              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = q_wr_i.push & ~full_o;
  assign do_pop  = pop_i & (cnt_q != '0);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.cls;
    end
  end

  assign q_rd_o.valid = (cnt_q != '0);
  assign q_rd_o.cls   = mem_q[rd_ptr_q];

endmodule

[hw/rtl/mwr_back.sv]
// Back end: Manchester decoder state, word assembly, parity check with
// polarity correction, frame word counting and the output register.
// Depends on mwr_pkg and mwr_out_if.
module mwr_back import mwr_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_rd_t     q_rd_i,
  output logic      pop_o,
  mwr_out_if.source out_ch
);

  localparam int unsigned BC_W = $clog2(WORD_BITS + 1);

  logic                 level_q, level_d;
  logic                 in_sync_q, in_sync_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic                 par_q, par_d;
  logic [BC_W-1:0]      bc_q, bc_d;
  logic [1:0]           hc_q, hc_d;
  logic                 cmd_q, cmd_d;
  logic [OUT_W-1:0]     wc_q, wc_d;

  logic                 emit;
  logic                 fixed;
  logic                 kept;
  logic [31:0]          word_ext;

  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_word_q, out_pos_q;
  logic                 out_cmd_q, out_kept_q, out_fix_q;

  // Take a class whenever the output register is free or draining
  assign pop_o = q_rd_i.valid & (~out_valid_q | out_ch.ready);

  // Decoder step
  always_comb begin
    logic [2:0] hc_sum;
    hc_sum    = 3'd0;
    level_d   = level_q;
    in_sync_d = in_sync_q;
    shift_d   = shift_q;
    par_d     = par_q;
    bc_d      = bc_q;
    hc_d      = hc_q;
    cmd_d     = cmd_q;
    wc_d      = wc_q;
    emit      = 1'b0;
    fixed     = 1'b0;
    kept      = 1'b0;

    if (pop_o) begin
      if (q_rd_i.cls == CLS_START) begin
        wc_d = '0;
      end else begin
        level_d = ~level_q;
        case (q_rd_i.cls)
          CLS_HALF, CLS_FULL: begin
            hc_sum = {1'b0, hc_q} + ((q_rd_i.cls == CLS_HALF) ? 3'd1 : 3'd2);
            hc_d   = (hc_sum >= 3'd3) ? 2'd3 : hc_sum[1:0];
            if (hc_sum >= 3'd3) begin
              in_sync_d = 1'b0;
            end
          end
          CLS_SYNC1, CLS_SYNC2: begin
            in_sync_d = 1'b1;
            shift_d   = '0;
            par_d     = 1'b1;
            bc_d      = '0;
            hc_d      = (q_rd_i.cls == CLS_SYNC1) ? 2'd1 : 2'd2;
            cmd_d     = level_q;  // command when level after edge is low
          end
          default: begin
            in_sync_d = 1'b0;
          end
        endcase

        // Full bit time pending: shift a data bit or close on parity
        if (in_sync_d && hc_d == 2'd2) begin
          if (bc_d < BC_W'(WORD_BITS)) begin
            shift_d = {shift_d[WORD_BITS-2:0], level_d};
            par_d   = par_d ^ level_d;
            bc_d    = bc_d + 1'b1;
            hc_d    = 2'd0;
          end else begin
            in_sync_d = 1'b0;
            emit      = 1'b1;
            if (level_d != par_d) begin
              level_d = ~level_d;
              shift_d = ~shift_d;
              cmd_d   = ~cmd_d;
              fixed   = 1'b1;
            end
            if (wc_q == '0) begin
              if (cmd_d) begin
                kept = 1'b1;
                wc_d = OUT_W'(1);
              end
            end else begin
              kept = (wc_q < cfg_i.max_words);
              if (wc_q != COUNT_MAX) begin
                wc_d = wc_q + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 1'b0;
      in_sync_q <= 1'b0;
      shift_q   <= '0;
      par_q     <= 1'b0;
      bc_q      <= '0;
      hc_q      <= '0;
      cmd_q     <= 1'b0;
      wc_q      <= '0;
    end else begin
      level_q   <= level_d;
      in_sync_q <= in_sync_d;
      shift_q   <= shift_d;
      par_q     <= par_d;
      bc_q      <= bc_d;
      hc_q      <= hc_d;
      cmd_q     <= cmd_d;
      wc_q      <= wc_d;
    end
  end

  // Output register
  assign word_ext    = 32'(shift_d);
  assign out_valid_d = emit | (out_valid_q & ~out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= word_ext[OUT_W-1:0];
      out_cmd_q  <= cmd_d;
      out_pos_q  <= wc_q;
      out_kept_q <= kept;
      out_fix_q  <= fixed;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.word           = out_word_q;
  assign out_ch.is_command     = out_cmd_q;
  assign out_ch.position       = out_pos_q;
  assign out_ch.kept           = out_kept_q;
  assign out_ch.polarity_fixed = out_fix_q;

`ifndef ASSERT_OFF
  // A word closes only after all data bits are in
  a_emit_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (bc_q == BC_W'(WORD_BITS)))
    else $error("word closed before all data bits were shifted");

  // Sync drops once a word is closed
  a_sync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !in_sync_q)
    else $error("still in sync after a word was closed");

  // Bit counter never passes the parity slot
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_W'(WORD_BITS))
    else $error("bit counter out of range");

  // A kept later word lies below the frame limit
  a_kept_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kept_q && out_pos_q != '0) |-> (out_pos_q < cfg_i.max_words))
    else $error("word kept beyond the frame limit");
`endif

endmodule

[hw/rtl/manchester_word_receiver.sv]
// Manchester word receiver, top level: configuration registers, front, queue, back.
// A word's result passes through the queue entry and then the output register before it shows on the output.
// Throughput: one edge item per cycle while the output does not stall; the back end's decoder step is combinational.
// A two-entry queue lets the front take up to two items while the output stalls.
// Reset (async, active low) clears decoder state and restores default thresholds.
// Depends on mwr_pkg, mwr_if, mwr_front, mwr_fifo and mwr_back.
module manchester_word_receiver import mwr_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IV_W-1:0]      cfg_wdata_i,
  mwr_in_if.sink               in_ch,
  mwr_out_if.source            out_ch
);

  cfg_t  cfg_q;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_max  <= HALF_BIT_MAX_RST;
      cfg_q.bit_max       <= BIT_MAX_RST;
      cfg_q.sync_half_max <= SYNC_HALF_MAX_RST;
      cfg_q.sync_max      <= SYNC_MAX_RST;
      cfg_q.max_words     <= MAX_WORDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_BIT_MAX:  cfg_q.half_bit_max  <= cfg_wdata_i;
        CFG_BIT_MAX:       cfg_q.bit_max       <= cfg_wdata_i;
        CFG_SYNC_HALF_MAX: cfg_q.sync_half_max <= cfg_wdata_i;
        CFG_SYNC_MAX:      cfg_q.sync_max      <= cfg_wdata_i;
        CFG_MAX_WORDS:     cfg_q.max_words     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  mwr_front u_front (
    .in_ch    (in_ch),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  mwr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  mwr_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .q_rd_i (q_rd),
    .pop_o  (q_pop),
    .out_ch (out_ch)
  );

endmodule

[tb/tb_manchester_word_receiver.sv]
// Self-checking testbench for manchester_word_receiver: a short table of edge
// items, then randomized Manchester words and noise under several threshold settings.
// Depends on mwr_pkg, mwr_if and the manchester_word_receiver RTL.
`timescale 1ns / 100ps

module tb_manchester_word_receiver;
  import mwr_pkg::*;

  localparam int WB         = WORD_BITS_DEF;
  localparam int DIR_N      = 25;
  localparam int N_PHASES   = 8;
  localparam int SETTLE     = 8;     // pipeline slack before a register write
  localparam int END_SETTLE = 20;
  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer

  typedef struct packed {
    logic [OUT_W-1:0] word;
    logic             is_command;
    logic [OUT_W-1:0] position;
    logic             kept;
    logic             polarity_fixed;
  } word_res_t;

  typedef struct {
    logic      op;
    logic [15:0] iv;
    bit        typed;    // result given by hand instead of by the decoder model
    bit        has_res;
    word_res_t res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [IV_W-1:0]      cfg_wdata_i;

  mwr_in_if  in_ch ();
  mwr_out_if out_ch ();

  manchester_word_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Decoder model state, thresholds and pending words
  cfg_t        thr = '{HALF_BIT_MAX_RST, BIT_MAX_RST, SYNC_HALF_MAX_RST,
                       SYNC_MAX_RST, MAX_WORDS_RST};
  logic        line_lvl   = 1'b0;
  logic        synced     = 1'b0;
  logic [WB-1:0] shreg    = '0;
  logic        par_acc    = 1'b0;
  int          bits_in    = 0;
  int          halves     = 0;
  logic        cmd_flag   = 1'b0;
  logic [OUT_W-1:0] frame_words = '0;

  word_res_t   word_q[$];
  dir_row_t    dir_rows[DIR_N];
  cfg_t        phase_cfg[N_PHASES];
  int          phase_len[N_PHASES];
  int          n_sent    = 0;
  int          n_acc     = 0;
  int          err_cnt   = 0;
  int          burst_left = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Decode one edge item; returns 1 when it closes a word
  function automatic bit decode_edge(input logic op, input logic [15:0] iv,
                                     output word_res_t r);
    r = '0;
    if (op) begin
      frame_words = '0;
      return 1'b0;
    end
    line_lvl = ~line_lvl;
    if (iv <= thr.bit_max) begin
      halves += (iv <= thr.half_bit_max) ? 1 : 2;
      if (halves > 3) halves = 3;
      if (halves >= 3) synced = 1'b0;
    end else if (iv > thr.sync_max) begin
      synced = 1'b0;
    end else begin
      synced   = 1'b1;
      shreg    = '0;
      par_acc  = 1'b1;
      bits_in  = 0;
      halves   = (iv <= thr.sync_half_max) ? 1 : 2;
      cmd_flag = ~line_lvl;
    end
    if (!(synced && halves == 2)) return 1'b0;

    // data bit
    if (bits_in < WB) begin
      shreg   = {shreg[WB-2:0], line_lvl};
      par_acc ^= line_lvl;
      bits_in++;
      halves  = 0;
      return 1'b0;
    end

    // parity bit closes the word; a mismatch means the line is inverted
    synced = 1'b0;
    if (line_lvl != par_acc) begin
      line_lvl = ~line_lvl;
      shreg    = ~shreg;
      cmd_flag = ~cmd_flag;
      r.polarity_fixed = 1'b1;
    end
    r.position = frame_words;
    if (frame_words == '0) begin
      if (cmd_flag) begin
        r.kept      = 1'b1;
        frame_words = OUT_W'(1);
      end
    end else begin
      r.kept = (frame_words < thr.max_words);
      if (frame_words != COUNT_MAX) frame_words++;
    end
    r.word       = shreg[OUT_W-1:0];
    r.is_command = cmd_flag;
    return 1'b1;
  endfunction

  // Random value in [lo, hi], ends favored; anything if the range is empty
  function automatic logic [15:0] pick(input int lo, input int hi);
    if (lo > hi) return 16'($urandom_range(65535, 0));
    case ($urandom_range(3, 0))
      0:       return 16'(lo);
      1:       return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // Interval that falls in the given class under the current thresholds
  function automatic logic [15:0] iv_of(input cls_e c);
    int h, b, sh, s;
    h  = thr.half_bit_max;
    b  = thr.bit_max;
    sh = thr.sync_half_max;
    s  = thr.sync_max;
    case (c)
      CLS_HALF:  return pick(0, (h < b) ? h : b);
      CLS_FULL:  return pick(h + 1, b);
      CLS_SYNC1: return pick(b + 1, (sh < s) ? sh : s);
      CLS_SYNC2: return pick(((b > sh) ? b : sh) + 1, s);
      default:   return pick(((b > s) ? b : s) + 1, 65535);
    endcase
  endfunction

  function automatic logic [15:0] noise_iv();
    if ($urandom_range(5, 0) == 0) return 16'($urandom_range(65535, 0));
    return iv_of(cls_e'($urandom_range(5, 1)));
  endfunction

  function automatic dir_row_t drow(input logic op, input logic [15:0] iv,
                                    input bit typed, input bit has_res,
                                    input word_res_t res);
    drow = '{op, iv, typed, has_res, res};
  endfunction

  // One edge transfer; the sender works in bursts with gaps between them
  task automatic send_item(input logic op, input logic [15:0] iv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.interval  <= iv;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // Sync, data bits and parity; a broken word stops early and gets noise
  task automatic send_word(input bit broken);
    int shifts, cut;
    if ($urandom_range(1, 0)) begin
      send_item(1'b0, iv_of(CLS_SYNC2));
    end else begin
      send_item(1'b0, iv_of(CLS_SYNC1));
      send_item(1'b0, iv_of(CLS_HALF));
    end
    shifts = 1;
    cut = broken ? $urandom_range(WB, 1) : WB + 1;
    while (shifts < cut) begin
      if ($urandom_range(2, 0) == 0) begin
        send_item(1'b0, iv_of(CLS_HALF));
        send_item(1'b0, iv_of(CLS_HALF));
      end else begin
        send_item(1'b0, iv_of(CLS_FULL));
      end
      shifts++;
    end
    if (broken) send_item($urandom_range(7, 0) == 0, noise_iv());
  endtask

  task automatic run_random(input int budget);
    int stop_at, r, k;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        send_item(1'b1, 16'($urandom_range(65535, 0)));
      end else if (r < 78) begin
        send_word(1'b0);
      end else if (r < 88) begin
        send_word(1'b1);
      end else begin
        k = $urandom_range(4, 1);
        repeat (k) send_item($urandom_range(9, 0) == 0, noise_iv());
      end
    end
  endtask

  // Stop sending, wait for every pending word, then let the pipeline settle;
  // the first edge lets the monitor log the last transfer before the check
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IV_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_HALF_BIT_MAX:  thr.half_bit_max  = val;
      CFG_BIT_MAX:       thr.bit_max       = val;
      CFG_SYNC_HALF_MAX: thr.sync_half_max = val;
      CFG_SYNC_MAX:      thr.sync_max      = val;
      CFG_MAX_WORDS:     thr.max_words     = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input cfg_t c);
    write_reg(CFG_HALF_BIT_MAX, c.half_bit_max);
    write_reg(CFG_BIT_MAX, c.bit_max);
    write_reg(CFG_SYNC_HALF_MAX, c.sync_half_max);
    write_reg(CFG_SYNC_MAX, c.sync_max);
    write_reg(CFG_MAX_WORDS, c.max_words);
    cfg_we_i <= 1'b0;
  endtask

  // Output ready follows a rotating pattern, reloaded whenever a random epoch count runs out
  initial begin : rx_stall
    logic [31:0] pat;
    int epoch;
    out_ch.ready <= 1'b0;
    pat   = '1;
    epoch = 0;
    forever begin
      @(posedge clk_i);
      if (epoch == 0) begin
        epoch = $urandom_range(64, 16);
        case ($urandom_range(2, 0))
          0:       pat = '1;
          1:       pat = $urandom;
          default: pat = $urandom & $urandom;
        endcase
        if (pat == '0) pat = 32'h1;
      end
      epoch--;
      out_ch.ready <= pat[0];
      pat = {pat[0], pat[31:1]};
    end
  end

  // Monitor: predict on input transfers, check output transfers, watchdog
  always @(posedge clk_i) begin : monitor
    word_res_t res, act, want;
    bit got, moved;
    int idle_cnt;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        got = decode_edge(in_ch.operation, in_ch.interval, res);
        if (n_acc < DIR_N && dir_rows[n_acc].typed) begin
          got = dir_rows[n_acc].has_res;
          res = dir_rows[n_acc].res;
        end
        if (got) word_q.push_back(res);
        n_acc++;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        act = '{out_ch.word, out_ch.is_command, out_ch.position, out_ch.kept,
                out_ch.polarity_fixed};
        moved = 1'b1;
        if (word_q.size() == 0) begin
          err_cnt++;
          $display({"%0t ns: unexpected word: expected none, ",
                    "actual word=%h cmd=%0b pos=%0d kept=%0b fixed=%0b"},
                   $time, act.word, act.is_command, act.position, act.kept,
                   act.polarity_fixed);
        end else begin
          want = word_q.pop_front();
          if (act.word !== want.word || act.is_command !== want.is_command ||
              act.position !== want.position || act.kept !== want.kept ||
              act.polarity_fixed !== want.polarity_fixed) begin
            err_cnt++;
            $display({"%0t ns: word mismatch: ",
                      "expected word=%h cmd=%0b pos=%0d kept=%0b fixed=%0b, ",
                      "actual word=%h cmd=%0b pos=%0d kept=%0b fixed=%0b"},
                     $time, want.word, want.is_command, want.position, want.kept,
                     want.polarity_fixed, act.word, act.is_command, act.position,
                     act.kept, act.polarity_fixed);
          end
        end
      end
      idle_cnt = moved ? 0 : idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t ns: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_manchester_word_receiver failed");
        $finish;
      end
    end else begin
      idle_cnt = 0;
    end
  end

  // Stimulus
  initial begin : stim
    int i, p;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= 1'b0;
    in_ch.interval  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_HALF_BIT_MAX;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;

    // Directed rows at reset thresholds: a data-sync word of alternating bits
    // (never kept, it opens no frame), then extremes and frame starts
    dir_rows[0] = drow(1'b0, 16'd110, 1'b0, 1'b0, '0);
    for (i = 1; i < 16; i++) dir_rows[i] = drow(1'b0, 16'd60, 1'b0, 1'b0, '0);
    dir_rows[16] = drow(1'b0, 16'd60, 1'b1, 1'b1, '{16'hAAAA, 1'b0, 16'd0, 1'b0, 1'b0});
    dir_rows[17] = drow(1'b0, 16'h0000, 1'b0, 1'b0, '0);
    dir_rows[18] = drow(1'b0, 16'hFFFF, 1'b0, 1'b0, '0);
    dir_rows[19] = drow(1'b1, 16'hFFFF, 1'b1, 1'b0, '0);
    dir_rows[20] = drow(1'b1, 16'h0000, 1'b1, 1'b0, '0);
    dir_rows[21] = drow(1'b0, 16'd123, 1'b0, 1'b0, '0);
    dir_rows[22] = drow(1'b0, 16'd41, 1'b0, 1'b0, '0);
    dir_rows[23] = drow(1'b0, 16'd42, 1'b0, 1'b0, '0);
    dir_rows[24] = drow(1'b0, 16'd122, 1'b0, 1'b0, '0);

    // Threshold settings; the first phase runs on the reset values
    phase_cfg[0] = thr;                                            phase_len[0] = 240;
    phase_cfg[1] = '{16'd10, 16'd20, 16'd30, 16'd40, 16'd3};       phase_len[1] = 200;
    phase_cfg[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1};           phase_len[2] = 30;
    phase_cfg[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_len[3] = 30;
    phase_cfg[4] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd1};           phase_len[4] = 200;
    phase_cfg[5] = '{16'd65531, 16'd65532, 16'd65533, 16'd65534, 16'hFFFF};
    phase_len[5] = 180;
    phase_cfg[6] = '{16'd500, 16'd100, 16'd50, 16'd300, 16'd2};    phase_len[6] = 60;
    phase_cfg[7] = '{HALF_BIT_MAX_RST, BIT_MAX_RST, SYNC_HALF_MAX_RST, SYNC_MAX_RST,
                     MAX_WORDS_RST};
    phase_len[7] = 160;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) send_item(dir_rows[i].op, dir_rows[i].iv);

    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain();
        set_thresholds(phase_cfg[p]);
      end
      run_random(phase_len[p]);
    end

    drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (err_cnt == 0 && word_q.size() == 0) begin
      $display("tb_manchester_word_receiver passed");
    end else begin
      $display("tb_manchester_word_receiver failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mwr_pkg.sv
hw/rtl/mwr_if.sv
hw/rtl/mwr_front.sv
hw/rtl/mwr_fifo.sv
hw/rtl/mwr_back.sv
hw/rtl/manchester_word_receiver.sv
tb/tb_manchester_word_receiver.sv
